// ----- hdl/gtc_pkg.sv -----
// ----------------------------------------------------------------------------
// gtc_pkg: shared definitions for the global timer with comparator
// Request function codes, register map, control bit positions and the
// request and result bundles that pass between the timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gtc_pkg;

  // Default counter and comparator width
  localparam int unsigned COUNTER_WIDTH_DEF = 64;

  // Request function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Register map
  localparam logic [2:0] REG_CNT_LO  = 3'd0;
  localparam logic [2:0] REG_CNT_HI  = 3'd1;
  localparam logic [2:0] REG_CTRL    = 3'd2;
  localparam logic [2:0] REG_STATUS  = 3'd3;
  localparam logic [2:0] REG_CMP_LO  = 3'd4;
  localparam logic [2:0] REG_CMP_HI  = 3'd5;
  localparam logic [2:0] REG_AUTOINC = 3'd6;

  // Control register bits
  localparam int unsigned CTL_ENABLE_BIT  = 0;
  localparam int unsigned CTL_CMP_EN_BIT  = 1;
  localparam int unsigned CTL_IRQ_EN_BIT  = 2;
  localparam int unsigned CTL_AUTOINC_BIT = 3;
  localparam logic [15:0] CTL_WMASK       = 16'hFF0F;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        event_pending;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/global_timer_with_comparator.sv -----
// ----------------------------------------------------------------------------
// global_timer_with_comparator: 64-bit global timer with comparator
// Register-level timer: each request is a tick, a register read or a register
// write; every request returns one result with read data, irq and event flag.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  in      | input     | in_valid_i/in_stall_o | func_i, reg_index_i, write_data_i
//  out     | output    | out_valid_o/out_stall_i | read_data_o, irq_o, event_pending_o
//
//  One request per clock sustained while the output does not stall; a result
//  passes through the input register, then the result register.
//  The critical path is the counter increment into the comparator compare.
//  Reset clears counter, comparator, control, step, prescale count and flag.
//  A stalled output holds its result; the input register still takes one
//  more request, and only then is in_stall_o raised.
// ----------------------------------------------------------------------------
`default_nettype none

module global_timer_with_comparator #(
  parameter int unsigned COUNTER_WIDTH = gtc_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  reg_index_i,
  input  wire logic [31:0] write_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_data_o,
  output logic             irq_o,
  output logic             event_pending_o
);

  // Input register
  logic             req_valid_q, req_valid_d;
  gtc_pkg::req_t    req_q;
  // Result register
  logic             res_valid_q, res_valid_d;
  gtc_pkg::result_t res_q;
  gtc_pkg::result_t core_result;

  logic in_accept;
  logic res_load;

  // Advance the held request whenever the result register is free or draining
  assign res_load   = req_valid_q & (~res_valid_q | ~out_stall_i);
  assign in_stall_o = req_valid_q & ~res_load;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign req_valid_d = in_accept | (req_valid_q & ~res_load);
  assign res_valid_d = res_load | (res_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Capture the request payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.func       <= func_i;
      req_q.reg_index  <= reg_index_i;
      req_q.write_data <= write_data_i;
    end
  end

  // Apply the request to the timer state as it moves to the result register
  gtc_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (res_load),
    .req_i    (req_q),
    .result_o (core_result)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= core_result;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign read_data_o     = res_q.read_data;
  assign irq_o           = res_q.irq;
  assign event_pending_o = res_q.event_pending;

  // Stall the input only while a request is held
  a_stall_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid_q)
    else $error("input stalled with empty request register");

  // Interrupt is never raised without a pending event
  a_irq_implies_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && irq_o |-> event_pending_o)
    else $error("irq without event flag");

  // A held request moves on as soon as the result side frees up
  a_req_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !res_valid_q |=> res_valid_q)
    else $error("held request did not advance");

endmodule

`default_nettype wire

// ----- hdl/gtc_core.sv -----
// ----------------------------------------------------------------------------
// gtc_core: timer state and single-step update
// Holds counter, comparator, control, step, prescale count and event flag;
// applies one request per asserted step and returns that request's result.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_core #(
  parameter int unsigned COUNTER_WIDTH = gtc_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire gtc_pkg::req_t    req_i,
  output gtc_pkg::result_t      result_o
);

  localparam int unsigned CW = COUNTER_WIDTH;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] compare_q, compare_d;
  logic [15:0]   ctrl_q, ctrl_d;
  logic [31:0]   step_q, step_d;
  logic          flag_q, flag_d;
  logic [7:0]    presc_cnt_q, presc_cnt_d;

  logic [CW-1:0] count_inc;
  logic [CW-1:0] compare_inc;
  logic [63:0]   count_ext;
  logic [63:0]   compare_ext;
  logic [63:0]   wr_lo_count, wr_hi_count, wr_lo_cmp, wr_hi_cmp;
  logic [31:0]   rd_data;

  assign count_inc   = count_q + CW'(1);
  assign compare_inc = compare_q + CW'(step_q);
  assign count_ext   = 64'(count_q);
  assign compare_ext = 64'(compare_q);
  assign wr_lo_count = {count_ext[63:32], req_i.write_data};
  assign wr_hi_count = {req_i.write_data, count_ext[31:0]};
  assign wr_lo_cmp   = {compare_ext[63:32], req_i.write_data};
  assign wr_hi_cmp   = {req_i.write_data, compare_ext[31:0]};

  always_comb begin
    count_d     = count_q;
    compare_d   = compare_q;
    ctrl_d      = ctrl_q;
    step_d      = step_q;
    flag_d      = flag_q;
    presc_cnt_d = presc_cnt_q;
    rd_data     = 32'd0;
    case (req_i.func)
      gtc_pkg::FUNC_TICK: begin
        if (ctrl_q[gtc_pkg::CTL_ENABLE_BIT]) begin
          if (presc_cnt_q < ctrl_q[15:8]) begin
            presc_cnt_d = presc_cnt_q + 8'd1;
          end else begin
            presc_cnt_d = 8'd0;
            count_d     = count_inc;
            if (ctrl_q[gtc_pkg::CTL_CMP_EN_BIT] && (count_inc >= compare_q)) begin
              flag_d = 1'b1;
              if (ctrl_q[gtc_pkg::CTL_AUTOINC_BIT]) begin
                compare_d = compare_inc;
              end
            end
          end
        end
      end
      gtc_pkg::FUNC_READ: begin
        case (req_i.reg_index)
          gtc_pkg::REG_CNT_LO:  rd_data = count_ext[31:0];
          gtc_pkg::REG_CNT_HI:  rd_data = count_ext[63:32];
          gtc_pkg::REG_CTRL:    rd_data = 32'(ctrl_q);
          gtc_pkg::REG_STATUS:  rd_data = 32'(flag_q);
          gtc_pkg::REG_CMP_LO:  rd_data = compare_ext[31:0];
          gtc_pkg::REG_CMP_HI:  rd_data = compare_ext[63:32];
          gtc_pkg::REG_AUTOINC: rd_data = step_q;
          default:              rd_data = 32'd0;
        endcase
      end
      gtc_pkg::FUNC_WRITE: begin
        case (req_i.reg_index)
          gtc_pkg::REG_CNT_LO: begin
            // counter is writable only while stopped
            if (!ctrl_q[gtc_pkg::CTL_ENABLE_BIT]) count_d = wr_lo_count[CW-1:0];
          end
          gtc_pkg::REG_CNT_HI: begin
            if (!ctrl_q[gtc_pkg::CTL_ENABLE_BIT]) count_d = wr_hi_count[CW-1:0];
          end
          gtc_pkg::REG_CTRL:    ctrl_d = req_i.write_data[15:0] & gtc_pkg::CTL_WMASK;
          gtc_pkg::REG_STATUS: begin
            if (req_i.write_data[0]) flag_d = 1'b0;
          end
          gtc_pkg::REG_CMP_LO:  compare_d = wr_lo_cmp[CW-1:0];
          gtc_pkg::REG_CMP_HI:  compare_d = wr_hi_cmp[CW-1:0];
          gtc_pkg::REG_AUTOINC: step_d = req_i.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o.read_data     = rd_data;
  assign result_o.irq           = flag_d & ctrl_d[gtc_pkg::CTL_IRQ_EN_BIT];
  assign result_o.event_pending = flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      compare_q   <= '0;
      ctrl_q      <= '0;
      step_q      <= '0;
      flag_q      <= 1'b0;
      presc_cnt_q <= '0;
    end else if (step_i) begin
      count_q     <= count_d;
      compare_q   <= compare_d;
      ctrl_q      <= ctrl_d;
      step_q      <= step_d;
      flag_q      <= flag_d;
      presc_cnt_q <= presc_cnt_d;
    end
  end

  // State moves only on an applied request
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(count_q) && $stable(compare_q) && $stable(flag_q))
    else $error("timer state changed without a request");

  // Event flag sets only from a tick
  a_flag_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> $past(step_i && (req_i.func == gtc_pkg::FUNC_TICK)))
    else $error("event flag set by a non-tick request");

  // Reserved control bits never hold a one
  a_ctrl_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q & ~gtc_pkg::CTL_WMASK) == 16'd0)
    else $error("reserved control bits set");

endmodule

`default_nettype wire
